// ===== rtl/indexed_array_list_macros.svh =====
// assertion macros shared by the list block
`ifndef INDEXED_ARRAY_LIST_MACROS_SVH
`define INDEXED_ARRAY_LIST_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define IAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ial_pkg.sv =====
package ial_pkg;

    // fixed field widths
    localparam int ACT_W = 3;
    localparam int IDX_W = 6;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_MODIFY = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    // memory read address select
    localparam logic [1:0] RD_NONE   = 2'd0;
    localparam logic [1:0] RD_POS    = 2'd1;
    localparam logic [1:0] RD_PTR_DN = 2'd2;
    localparam logic [1:0] RD_PTR_UP = 2'd3;

    // memory write select
    localparam logic [1:0] WR_NONE     = 2'd0;
    localparam logic [1:0] WR_POS_VAL  = 2'd1;
    localparam logic [1:0] WR_PTR_DATA = 2'd2;

    // shift pointer operation
    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_CNT  = 3'd1;
    localparam logic [2:0] PTR_POS  = 3'd2;
    localparam logic [2:0] PTR_DEC  = 3'd3;
    localparam logic [2:0] PTR_INC  = 3'd4;

    // element count operation
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic [1:0]       rd_sel;
        logic [1:0]       wr_sel;
        logic [2:0]       ptr_op;
        logic [1:0]       cnt_op;
        logic             reply;
        logic [ST_W-1:0]  status;
        logic             use_rdata;
    } ial_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             idx_ok;
        logic             full;
        logic             ins_more;
        logic             del_more;
    } ial_stat_t;

endpackage

// ===== rtl/ial_datapath.sv =====
module ial_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ial_pkg::ial_cmd_t                    cmd,
    output ial_pkg::ial_stat_t                   stat,
    input  logic [ial_pkg::ACT_W-1:0]            action,
    input  logic [ial_pkg::IDX_W-1:0]            item_index,
    input  logic signed [ial_pkg::VAL_W-1:0]     item_value,
    output logic                                 done,
    output logic signed [ial_pkg::VAL_W-1:0]     read_value,
    output logic [$clog2(CAPACITY+1)-1:0]        element_total,
    output logic [ial_pkg::ST_W-1:0]             status
);
    import ial_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // element store, one write and one registered read per cycle
    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rdata_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [ACT_W-1:0] act_reg;
    logic [CW-1:0]    pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic             idx_ok_reg;
    logic             full_reg;

    logic             done_reg;
    logic [VAL_W-1:0] read_value_reg;
    logic [CNT_W-1:0] total_reg;
    logic [ST_W-1:0]  status_reg;

    logic             rd_en;
    logic [AW-1:0]    raddr;
    logic             wr_en;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic [CW-1:0]    idx_ext;
    logic [CW-1:0]    cnt_ext;
    logic [CW-1:0]    pos_in;

    // index checks against the current count
    assign idx_ext = CW'(item_index);
    assign cnt_ext = CW'(count_reg);
    assign pos_in  = (action == ACT_APPEND || idx_ext > cnt_ext) ? cnt_ext : idx_ext;

    // item latch
    always_ff @(posedge clk) begin
        if (cmd.load)
        begin
            act_reg    <= action;
            val_reg    <= item_value;
            pos_reg    <= pos_in;
            idx_ok_reg <= idx_ext < cnt_ext;
            full_reg   <= count_reg == CNT_W'(CAPACITY);
        end
    end

    // shift pointer
    always_comb begin
        case (cmd.ptr_op)
            PTR_CNT:  ptr_next = count_reg;
            PTR_POS:  ptr_next = CNT_W'(pos_reg);
            PTR_DEC:  ptr_next = ptr_reg - CNT_W'(1);
            PTR_INC:  ptr_next = ptr_reg + CNT_W'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk) begin
        ptr_reg <= ptr_next;
    end

    // element count
    always_comb begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // memory address selection
    always_comb begin
        rd_en = 1'b1;
        case (cmd.rd_sel)
            RD_POS:    raddr = AW'(pos_reg);
            RD_PTR_DN: raddr = AW'(ptr_reg - CNT_W'(1));
            RD_PTR_UP: raddr = AW'(ptr_reg + CNT_W'(1));
            default:
            begin
                raddr = AW'(pos_reg);
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        wr_en = 1'b1;
        case (cmd.wr_sel)
            WR_POS_VAL:
            begin
                waddr = AW'(pos_reg);
                wdata = val_reg;
            end
            WR_PTR_DATA:
            begin
                waddr = AW'(ptr_reg);
                wdata = rdata_reg;
            end
            default:
            begin
                waddr = AW'(pos_reg);
                wdata = val_reg;
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // result register, one beat per reply
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.reply;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.reply)
        begin
            read_value_reg <= cmd.use_rdata ? rdata_reg : '0;
            total_reg      <= count_next;
            status_reg     <= cmd.status;
        end
    end

    // status toward the controller
    assign stat.act      = act_reg;
    assign stat.idx_ok   = idx_ok_reg;
    assign stat.full     = full_reg;
    assign stat.ins_more = CW'(ptr_reg) > pos_reg;
    assign stat.del_more = ((CNT_W+1)'(ptr_reg) + (CNT_W+1)'(1)) < (CNT_W+1)'(count_reg);

    assign done          = done_reg;
    assign read_value    = read_value_reg;
    assign element_total = total_reg;
    assign status        = status_reg;

endmodule

// ===== rtl/ial_ctrl.sv =====
module ial_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ial_pkg::ial_stat_t  stat,
    output ial_pkg::ial_cmd_t   cmd
);
    import ial_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_READ_WAIT = 3'd2;
    localparam logic [2:0] S_INS_CHK   = 3'd3;
    localparam logic [2:0] S_INS_WR    = 3'd4;
    localparam logic [2:0] S_DEL_CHK   = 3'd5;
    localparam logic [2:0] S_DEL_WR    = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.rd_sel    = RD_NONE;
        cmd.wr_sel    = WR_NONE;
        cmd.ptr_op    = PTR_HOLD;
        cmd.cnt_op    = CNT_HOLD;
        cmd.reply     = 1'b0;
        cmd.status    = ST_OK;
        cmd.use_rdata = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (stat.act)
                    ACT_READ:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.rd_sel = RD_POS;
                            state_next = S_READ_WAIT;
                        end
                        else
                        begin
                            cmd.reply  = 1'b1;
                            cmd.status = ST_BAD;
                        end
                    end
                    ACT_MODIFY:
                    begin
                        cmd.reply = 1'b1;
                        if (stat.idx_ok)
                        begin
                            cmd.wr_sel = WR_POS_VAL;
                        end
                        else
                        begin
                            cmd.status = ST_BAD;
                        end
                    end
                    ACT_INSERT, ACT_APPEND:
                    begin
                        if (stat.full)
                        begin
                            cmd.reply  = 1'b1;
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_CNT;
                            state_next = S_INS_CHK;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.ptr_op = PTR_POS;
                            state_next = S_DEL_CHK;
                        end
                        else
                        begin
                            cmd.reply  = 1'b1;
                            cmd.status = ST_BAD;
                        end
                    end
                    default:
                    begin
                        cmd.reply = 1'b1;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                cmd.reply     = 1'b1;
                cmd.use_rdata = 1'b1;
                state_next    = S_IDLE;
            end
            // move elements up from the tail, then drop the value in
            S_INS_CHK:
            begin
                if (stat.ins_more)
                begin
                    cmd.rd_sel = RD_PTR_DN;
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.wr_sel = WR_POS_VAL;
                    cmd.cnt_op = CNT_INC;
                    cmd.reply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_sel = WR_PTR_DATA;
                cmd.ptr_op = PTR_DEC;
                state_next = S_INS_CHK;
            end
            // pull later elements down over the deleted one
            S_DEL_CHK:
            begin
                if (stat.del_more)
                begin
                    cmd.rd_sel = RD_PTR_UP;
                    state_next = S_DEL_WR;
                end
                else
                begin
                    cmd.cnt_op = CNT_DEC;
                    cmd.reply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DEL_WR:
            begin
                cmd.wr_sel = WR_PTR_DATA;
                cmd.ptr_op = PTR_INC;
                state_next = S_DEL_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;

endmodule

// ===== rtl/indexed_array_list.sv =====
// Ordered list of up to CAPACITY signed 32-bit values with read, modify,
// insert, append and delete by index. An item is taken when start is high
// and busy is low; its result comes back as a single beat on the cycle that
// done is high, and the receiver must take it then, as it cannot stall the
// block. A modify or any refused action is answered from the dispatch state,
// a read after a registered read of the element memory, and an insert,
// append or delete after moving m elements (up to CAPACITY - 1). Each
// moved element is read from the element memory into a holding register
// and then written back one place over. busy stays high until the result
// beat is issued, and the next item may start on that same beat.
`include "indexed_array_list_macros.svh"

module indexed_array_list #(
    parameter int CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ial_pkg::ACT_W-1:0]            action,
    input  logic [ial_pkg::IDX_W-1:0]            item_index,
    input  logic signed [ial_pkg::VAL_W-1:0]     item_value,
    output logic                                 done,
    output logic signed [ial_pkg::VAL_W-1:0]     read_value,
    output logic [$clog2(CAPACITY+1)-1:0]        element_total,
    output logic [ial_pkg::ST_W-1:0]             status
);
    import ial_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    ial_cmd_t  cmd;
    ial_stat_t stat;

    ial_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ial_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .item_index    (item_index),
        .item_value    (item_value),
        .done          (done),
        .read_value    (read_value),
        .element_total (element_total),
        .status        (status)
    );

    // checks
    `IAL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `IAL_ASSERT_NOW(a_done_after_work, done, $past(busy), "result beat without work")
    `IAL_ASSERT_NOW(a_total_range, done, element_total <= CNT_W'(CAPACITY), "count over capacity")
    `IAL_ASSERT_NOW(a_fail_zero, done && status != ST_OK, read_value == '0, "failed action read data")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ial_pkg::*;

    localparam int CAP     = 64;
    localparam int TOTAL_W = $clog2(CAP + 1);

    // action codes the block ignores
    localparam logic [ACT_W-1:0] ACT_SPARE0 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE1 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE2 = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // how the random part leans
    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} stim_mode_t;

    // one expected result beat
    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [TOTAL_W-1:0]      total;
        logic [ST_W-1:0]         status;
    } list_result_t;

    // shadow list and queue of expected result beats
    class list_scoreboard;
        logic signed [VAL_W-1:0] cells [CAP];
        int unsigned             fill;
        list_result_t            expected_q [$];
        int                      errors;
        int                      items;
        int                      checked;
        int                      full_hits;
        int                      bad_hits;
        int                      ignored;
        int unsigned             peak_fill;

        function new();
            foreach (cells[i]) cells[i] = '0;
            fill      = 0;
            errors    = 0;
            items     = 0;
            checked   = 0;
            full_hits = 0;
            bad_hits  = 0;
            ignored   = 0;
            peak_fill = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // apply one accepted beat to the shadow list
        function void note_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                logic signed [VAL_W-1:0] val);
            list_result_t res;
            int unsigned  pos;
            int unsigned  k;
            res.value  = '0;
            res.status = ST_OK;
            case (act)
                ACT_READ:
                    if (idx < fill) res.value = cells[idx];
                    else res.status = ST_BAD;
                ACT_MODIFY:
                    if (idx < fill) cells[idx] = val;
                    else res.status = ST_BAD;
                ACT_INSERT, ACT_APPEND:
                    if (fill >= CAP) begin
                        res.status = ST_FULL;
                    end else begin
                        // append, or insert past the end, lands at the tail
                        pos = (act == ACT_APPEND || idx > fill) ? fill : idx;
                        for (k = fill; k > pos; k--) cells[k] = cells[k-1];
                        cells[pos] = val;
                        fill++;
                    end
                ACT_DELETE:
                    if (idx < fill) begin
                        for (k = idx; k + 1 < fill; k++) cells[k] = cells[k+1];
                        fill--;
                    end else begin
                        res.status = ST_BAD;
                    end
                default:
                    ignored++;
            endcase
            res.total = fill[TOTAL_W-1:0];
            if (res.status == ST_FULL) full_hits++;
            if (res.status == ST_BAD) bad_hits++;
            if (fill > peak_fill) peak_fill = fill;
            items++;
            expected_q.push_back(res);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic signed [VAL_W-1:0] value,
                                   logic [TOTAL_W-1:0] total, logic [ST_W-1:0] st);
            list_result_t exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing pending: value %h total %0d status %0d",
                         $time, value, total, st);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (value !== exp_res.value) begin
                $display("%0t: read_value expected %h actual %h", $time, exp_res.value, value);
                errors++;
            end
            if (total !== exp_res.total) begin
                $display("%0t: element_total expected %0d actual %0d",
                         $time, exp_res.total, total);
                errors++;
            end
            if (st !== exp_res.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_res.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [ACT_W-1:0]          action;
    logic [IDX_W-1:0]          item_index;
    logic signed [VAL_W-1:0]   item_value;
    logic                      done;
    logic signed [VAL_W-1:0]   read_value;
    logic [TOTAL_W-1:0]        element_total;
    logic [ST_W-1:0]           status;

    list_scoreboard sb = new();
    int             idle_pct;

    indexed_array_list #(
        .CAPACITY(CAP)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .item_index   (item_index),
        .item_value   (item_value),
        .done         (done),
        .read_value   (read_value),
        .element_total(element_total),
        .status       (status)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result beats are taken on the edge that ends the done cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(read_value, element_total, status);
    end

    // hold the sender until every expected beat has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // issue one beat and wait for the block to take it
    task automatic send_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                             logic signed [VAL_W-1:0] val);
        int gap;
        start      <= 1'b1;
        action     <= act;
        item_index <= idx;
        item_value <= val;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(act, idx, val);
        // random sender gap, with junk on the fields while start is low
        if ($urandom_range(99) < idle_pct) begin
            start      <= 1'b0;
            action     <= ACT_W'($urandom);
            item_index <= IDX_W'($urandom);
            item_value <= $urandom;
            if ($urandom_range(3) == 0) gap = $urandom_range(140, 1);
            else gap = $urandom_range(3, 1);
            repeat (gap) @(posedge clk);
        end
        if (idle_pct != 0 && $urandom_range(49) == 0)
            wait_drained();
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(19))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // index mostly within reach of the list, sometimes anywhere
    function automatic logic [IDX_W-1:0] pick_index(logic [ACT_W-1:0] act);
        if ($urandom_range(4) == 0) return IDX_W'($urandom_range(CAP - 1, 0));
        if (act == ACT_INSERT) return IDX_W'($urandom_range(sb.fill, 0));
        if (sb.fill == 0) return '0;
        return IDX_W'($urandom_range(sb.fill - 1, 0));
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(stim_mode_t mode);
        int r;
        r = $urandom_range(99);
        if (r >= 96) return ACT_W'($urandom_range(ACT_SPARE2, ACT_SPARE0));
        case (mode)
            MODE_GROW:
                return r < 45 ? ACT_INSERT : r < 65 ? ACT_APPEND : r < 78 ? ACT_READ :
                       r < 88 ? ACT_MODIFY : ACT_DELETE;
            MODE_SHRINK:
                return r < 55 ? ACT_DELETE : r < 70 ? ACT_READ : r < 80 ? ACT_MODIFY :
                       r < 90 ? ACT_INSERT : ACT_APPEND;
            default:
                return r < 20 ? ACT_READ : r < 38 ? ACT_MODIFY : r < 58 ? ACT_INSERT :
                       r < 72 ? ACT_APPEND : ACT_DELETE;
        endcase
    endfunction

    task automatic run_random(int count);
        stim_mode_t       mode;
        logic [ACT_W-1:0] act;
        int               n;
        mode = MODE_MIXED;
        for (n = 0; n < count; n++) begin
            if (n % 10 == 0) mode = stim_mode_t'($urandom_range(2));
            act = pick_action(mode);
            send_item(act, pick_index(act), pick_value());
        end
    endtask

    // grow to capacity, then poke the full list
    task automatic fill_list();
        logic [ACT_W-1:0] act;
        while (sb.fill < CAP) begin
            act = ($urandom_range(9) < 7) ? ACT_INSERT : ACT_APPEND;
            send_item(act, pick_index(act), pick_value());
        end
        send_item(ACT_INSERT, IDX_W'($urandom_range(CAP - 1, 0)), pick_value());
        send_item(ACT_APPEND, IDX_W'($urandom_range(CAP - 1, 0)), pick_value());
        send_item(ACT_READ, IDX_W'(CAP - 1), pick_value());
        send_item(ACT_MODIFY, IDX_W'($urandom_range(CAP - 1, 0)), pick_value());
    endtask

    // empty the list with deletes at random positions, reads mixed in
    task automatic drain_list();
        while (sb.fill > 0) begin
            if ($urandom_range(4) == 0)
                send_item(ACT_READ, pick_index(ACT_READ), pick_value());
            else
                send_item(ACT_DELETE, pick_index(ACT_DELETE), pick_value());
        end
        send_item(ACT_DELETE, IDX_W'($urandom_range(CAP - 1, 0)), pick_value());
    endtask

    task automatic run_directed();
        // refusals on an empty list, delete included
        send_item(ACT_READ, 0, VAL_MAX);
        send_item(ACT_DELETE, 0, VAL_MIN);
        send_item(ACT_MODIFY, 0, -1);
        // build [min, 0, max, -1], last one clamped from a far index
        send_item(ACT_APPEND, 63, VAL_MAX);
        send_item(ACT_INSERT, 0, VAL_MIN);
        send_item(ACT_INSERT, 63, -1);
        send_item(ACT_INSERT, 1, '0);
        send_item(ACT_READ, 0, '0);
        send_item(ACT_READ, 3, '0);
        send_item(ACT_READ, 4, '0);
        send_item(ACT_MODIFY, 1, 32'sh5555_5555);
        send_item(ACT_READ, 1, '0);
        // delete shifts the tail down
        send_item(ACT_DELETE, 0, '0);
        send_item(ACT_READ, 0, '0);
        send_item(ACT_DELETE, 2, '0);
        send_item(ACT_DELETE, 2, '0);
        // unused codes leave the list alone
        send_item(ACT_SPARE0, 63, -1);
        send_item(ACT_SPARE1, 0, VAL_MIN);
        send_item(ACT_SPARE2, 42, VAL_MAX);
        send_item(ACT_APPEND, 0, 32'shaaaa_aaaa);
        send_item(ACT_READ, 63, '0);
        // insert exactly at the end
        send_item(ACT_INSERT, 3, 32'sd1);
        send_item(ACT_DELETE, 0, '0);
    endtask

    initial
    begin
        int guard;
        int phase;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = ACT_READ;
        item_index = '0;
        item_value = '0;
        idle_pct   = 24;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        run_directed();
        wait_drained();

        // sender idles now and then, then often, then never
        // the first and last phases also run the list up to full and back down
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 24 : (phase == 1) ? 81 : 0;
            run_random((phase == 1) ? 60 : 20);
            if (phase != 1)
                fill_list();
            run_random(5);
            if (phase != 1)
                drain_list();
            wait_drained();
        end

        // let any stray beat show up before closing
        guard = 0;
        while (sb.pending() != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected result beats never arrived", $time, sb.pending());
            sb.errors += sb.pending();
        end

        $display("tb: %0d beats issued, %0d results checked, list peaked at %0d of %0d",
                 sb.items, sb.checked, sb.peak_fill, CAP);
        $display("tb: %0d full refusals, %0d bad-index refusals, %0d unused codes",
                 sb.full_hits, sb.bad_hits, sb.ignored);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== indexed_array_list.f =====
+incdir+rtl
rtl/ial_pkg.sv
rtl/ial_datapath.sv
rtl/ial_ctrl.sv
rtl/indexed_array_list.sv
tb/tb.sv
